// ===== sv/det_pkg.sv =====
package det_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 8;
    localparam int NAME_W     = 64;
    localparam int BLOCK_W    = 9;
    localparam int ACTION_W   = 2;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int IDX_W      = $clog2(ENTRIES);

    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_REFUSED   = 2'd3
    } status_t;

    localparam logic [NAME_W-1:0] NAME_DOT    = 64'h2E00_0000_0000_0000;
    localparam logic [NAME_W-1:0] NAME_DOTDOT = 64'h2E2E_0000_0000_0000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NAME_W-1:0]   entry_name;
        logic [BLOCK_W-1:0]  block_number;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLOCK_W-1:0] found_block;
        logic [CNT_W-1:0]   entry_count;
    } response_t;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [BLOCK_W-1:0] block;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    append;
        logic    scan_rd;
        logic    fetch;
        logic    move;
        logic    respond;
        logic    found;
        status_t code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                empty;
        logic                reserved;
        logic                hit;
        logic                at_last;
        logic                more;
    } stat_t;

    // Keep the first NAME_BYTES bytes from the top, cut at the first zero byte.
    function automatic logic [NAME_W-1:0] name_form(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        logic              cut;
        kept = '0;
        cut  = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[NAME_W-1-8*i -: 8] == 8'h00)
            begin
                cut = 1'b1;
            end
            if (!cut)
            begin
                kept[NAME_W-1-8*i -: 8] = raw[NAME_W-1-8*i -: 8];
            end
        end
        return kept;
    endfunction

    localparam logic [NAME_W-1:0] DOT_FORM    = name_form(NAME_DOT);
    localparam logic [NAME_W-1:0] DOTDOT_FORM = name_form(NAME_DOTDOT);

endpackage

// ===== sv/det_ctrl.sv =====
module det_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  det_pkg::stat_t stat,
    output det_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FETCH  = 5'b01000,
        S_MOVE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = det_pkg::STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (stat.action == det_pkg::ACT_CREATE)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                    if (stat.full)
                    begin
                        cmd.code = det_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
                else if (stat.action == det_pkg::ACT_REMOVE && stat.reserved)
                begin
                    cmd.respond = 1'b1;
                    cmd.code    = det_pkg::STAT_REFUSED;
                    state_next  = S_IDLE;
                end
                else if (stat.action == det_pkg::ACT_SEARCH
                         || stat.action == det_pkg::ACT_REMOVE)
                begin
                    if (stat.empty)
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = det_pkg::STAT_NOT_FOUND;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_rd = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
                else
                begin
                    // unused action: no change, plain ok
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    if (stat.action == det_pkg::ACT_SEARCH)
                    begin
                        cmd.respond = 1'b1;
                        cmd.found   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.fetch  = 1'b1;
                        state_next = S_FETCH;
                    end
                end
                else if (stat.at_last)
                begin
                    cmd.respond = 1'b1;
                    cmd.code    = det_pkg::STAT_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else if (stat.more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_FETCH:
            begin
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move    = 1'b1;
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_move_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> $past(state_reg == S_FETCH))
        else $error("move without fetch of last entry");

    a_fetch_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (stat.action == det_pkg::ACT_REMOVE))
        else $error("fetch outside a remove");

endmodule

// ===== sv/det_dpath.sv =====
module det_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  det_pkg::request_t  request,
    input  det_pkg::cmd_t      cmd,
    output det_pkg::stat_t     stat,
    output det_pkg::response_t response,
    output logic               done
);

    det_pkg::entry_t mem [det_pkg::ENTRIES];

    logic [det_pkg::ACTION_W-1:0] action_reg;
    logic [det_pkg::NAME_W-1:0]   name_reg;
    logic [det_pkg::BLOCK_W-1:0]  block_reg;
    logic [det_pkg::CNT_W-1:0]    count_reg;
    logic [det_pkg::CNT_W-1:0]    count_next;
    logic [det_pkg::CNT_W-1:0]    scan_idx_reg;
    logic [det_pkg::CNT_W-1:0]    cmp_idx_reg;
    logic                         rd_valid_reg;
    det_pkg::entry_t              rd_data_reg;
    det_pkg::response_t           res_reg;
    logic                         done_reg;

    logic                         we;
    logic [det_pkg::IDX_W-1:0]    wr_addr;
    det_pkg::entry_t              wr_data;
    logic                         re;
    logic [det_pkg::IDX_W-1:0]    rd_addr;
    logic [det_pkg::CNT_W-1:0]    last_idx;

    assign last_idx = count_reg - det_pkg::CNT_W'(1);

    always_comb
    begin
        we      = cmd.append | cmd.move;
        wr_addr = cmd.move ? cmp_idx_reg[det_pkg::IDX_W-1:0] : count_reg[det_pkg::IDX_W-1:0];
        wr_data = cmd.move ? rd_data_reg : det_pkg::entry_t'{name: name_reg, block: block_reg};
        re      = cmd.scan_rd | cmd.fetch;
        rd_addr = cmd.fetch ? last_idx[det_pkg::IDX_W-1:0] : scan_idx_reg[det_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + det_pkg::CNT_W'(1);
        end
        else if (cmd.move)
        begin
            count_next = last_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= request.action;
            name_reg   <= det_pkg::name_form(request.entry_name);
            block_reg  <= request.block_number;
        end
        if (cmd.scan_rd)
        begin
            cmp_idx_reg <= scan_idx_reg;
        end
        if (cmd.respond)
        begin
            res_reg.status      <= cmd.code;
            res_reg.found_block <= cmd.found ? rd_data_reg.block : '0;
            res_reg.entry_count <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_valid_reg <= cmd.scan_rd;
            done_reg     <= cmd.respond;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + det_pkg::CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        stat.action   = action_reg;
        stat.full     = (count_reg == det_pkg::CNT_W'(det_pkg::ENTRIES));
        stat.empty    = (count_reg == '0);
        stat.reserved = (name_reg == det_pkg::DOT_FORM) || (name_reg == det_pkg::DOTDOT_FORM);
        stat.hit      = rd_valid_reg && (rd_data_reg.name == name_reg);
        stat.at_last  = rd_valid_reg && (cmp_idx_reg == last_idx);
        stat.more     = (scan_idx_reg < count_reg);
    end

    assign response = res_reg;
    assign done     = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= det_pkg::CNT_W'(det_pkg::ENTRIES))
        else $error("entry count above table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + det_pkg::CNT_W'(1)
             || count_reg == $past(count_reg) - det_pkg::CNT_W'(1)))
        else $error("entry count jumped");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("two results back to back");

endmodule

// ===== sv/directory_entry_table_unit.sv =====
// Steps, accept to result strobe: create and unused actions decide and answer directly,
// search scans the held entries, remove also fetches the last entry and moves it over the hit.
// One item at a time; results cannot be stalled, and busy drops in the cycle
// the result shows, so a new item can start then; a full 16-entry scan sets the worst case.
// The entry table is a single-port-read memory scanned one entry per cycle.
// Reset (rst_n, async low) empties the table; entry contents are not cleared.
module directory_entry_table_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  det_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output det_pkg::response_t response
);

    // command and status between controller and datapath
    det_pkg::cmd_t  cmd;
    det_pkg::stat_t stat;

    // controller: decides per action, steps the scan, fetches/moves on remove
    det_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: entry memory, count, compare and result register
    det_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .stat     (stat),
        .response (response),
        .done     (done)
    );

endmodule
